// ===== hw/rtl/tts_pkg.sv =====
// ----------------------------------------------------------------------------
// tts_pkg: shared types and constants for the 4x4 texture tile swizzler
// Texel formats, register indexes, and the structs passed between units.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int unsigned MaxDimensionDef = 1024;
  localparam int unsigned TileEdge        = 4;

  localparam int unsigned CoordW  = 10;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned DimW    = 11;
  localparam int unsigned TilesW  = 9;   // at most 2047/4 tiles along a row
  localparam int unsigned RowW    = CoordW - 2;
  localparam int unsigned ProdW   = RowW + TilesW;
  localparam int unsigned TileIdxW = ProdW + 1;
  localparam int unsigned SlotW   = 5;
  localparam int unsigned OffsetW = 22;
  localparam int unsigned WordW   = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam int unsigned InDataW  = 56;  // 52 bits of fields, byte padded
  localparam int unsigned OutDataW = 40;  // 38 bits of fields, byte padded

  localparam logic [DimW-1:0] DimResetVal = 11'd1024;
  localparam logic [ByteW-1:0] AlphaOpaque = 8'hFF;
  localparam logic [OffsetW-1:0] HalfTileBytes = 22'd32;

  typedef enum logic [1:0] {
    FMT_RGBA8888 = 2'd0,
    FMT_RGB888   = 2'd1,
    FMT_RGB565   = 2'd2,
    FMT_RGBA4444 = 2'd3
  } fmt_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FORMAT = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_e;

  // settings seen by the datapath, derived from the registers
  typedef struct packed {
    fmt_e              fmt;
    logic [DimW-1:0]   span_x;
    logic [DimW-1:0]   span_y;
    logic [TilesW-1:0] tiles_x;
  } cfg_t;

  // one placed texel waiting for the output port
  typedef struct packed {
    logic [OffsetW-1:0] offset;
    logic [WordW-1:0]   word0;
    logic [WordW-1:0]   word1;
    logic               two_words;
  } item_t;

endpackage

// ===== hw/rtl/tts_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tts_cfg_regs: configuration registers
// Holds format and texture size; derives usable spans and tiles per row.
// ----------------------------------------------------------------------------
module tts_cfg_regs
  import tts_pkg::*;
#(
  parameter int unsigned MaxDimension = MaxDimensionDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_addr_i,
  input  logic [DimW-1:0]    cfg_wdata_i,
  output cfg_t               cfg_o
);

  fmt_e            fmt_q, fmt_d;
  logic [DimW-1:0] width_q, width_d;
  logic [DimW-1:0] height_q, height_d;
  logic [DimW-1:0] dim_x, dim_y;

  always_comb begin
    fmt_d    = fmt_q;
    width_d  = width_q;
    height_d = height_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_FORMAT: fmt_d    = fmt_e'(cfg_wdata_i[1:0]);
        CFG_WIDTH:  width_d  = cfg_wdata_i;
        CFG_HEIGHT: height_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= FMT_RGBA8888;
      width_q  <= DimResetVal;
      height_q <= DimResetVal;
    end else begin
      fmt_q    <= fmt_d;
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  // clamp to the largest supported dimension
  assign dim_x = (32'(width_q) > MaxDimension) ? DimW'(MaxDimension) : width_q;
  assign dim_y = (32'(height_q) > MaxDimension) ? DimW'(MaxDimension) : height_q;

  always_comb begin
    cfg_o.fmt     = fmt_q;
    // small dimensions keep all texels in one padded tile
    cfg_o.span_x  = (dim_x < DimW'(TileEdge)) ? dim_x : {dim_x[DimW-1:2], 2'b00};
    cfg_o.span_y  = (dim_y < DimW'(TileEdge)) ? dim_y : {dim_y[DimW-1:2], 2'b00};
    cfg_o.tiles_x = (dim_x < DimW'(TileEdge)) ? TilesW'(1) : dim_x[DimW-1:2];
  end

endmodule

// ===== hw/rtl/tts_pipe.sv =====
// ----------------------------------------------------------------------------
// tts_pipe: three-stage placement pipeline
// Stage 1 range check and word build, stage 2 row multiply, stage 3 offset.
// ----------------------------------------------------------------------------
module tts_pipe
  import tts_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              in_valid_i,
  input  logic [CoordW-1:0] texel_x_i,
  input  logic [CoordW-1:0] texel_y_i,
  input  logic [ByteW-1:0]  src_byte0_i,
  input  logic [ByteW-1:0]  src_byte1_i,
  input  logic [ByteW-1:0]  src_byte2_i,
  input  logic [ByteW-1:0]  src_byte3_i,
  input  cfg_t              cfg_i,
  output logic              out_valid_o,
  output item_t             out_item_o
);

  // stage 1
  logic              v1_q, v1_d;
  logic [RowW-1:0]   row1_q, col1_q;
  logic [SlotW-1:0]  slot1_q, slot1_d;
  logic              wide1_q, wide1_d;
  logic [WordW-1:0]  w0_1_q, w0_1_d, w1_1_q, w1_1_d;
  // stage 2
  logic              v2_q;
  logic [ProdW-1:0]  prod2_q;
  logic [RowW-1:0]   col2_q;
  logic [SlotW-1:0]  slot2_q;
  logic              wide2_q;
  logic [WordW-1:0]  w0_2_q, w1_2_q;
  // stage 3
  logic              v3_q;
  item_t             item3_q, item3_d;

  logic              in_range;
  logic [ByteW-1:0]  alpha;
  logic [WordW-1:0]  t16;
  logic [TileIdxW-1:0] tile_idx;

  assign in_range = ({1'b0, texel_x_i} < cfg_i.span_x) &&
                    ({1'b0, texel_y_i} < cfg_i.span_y);

  always_comb begin
    v1_d    = in_valid_i && in_range;
    slot1_d = {texel_y_i[1:0], texel_x_i[1:0], 1'b0};
    wide1_d = (cfg_i.fmt == FMT_RGBA8888) || (cfg_i.fmt == FMT_RGB888);
    alpha   = (cfg_i.fmt == FMT_RGBA8888) ? src_byte3_i : AlphaOpaque;
    t16     = {src_byte0_i, src_byte1_i};
    w1_1_d  = {src_byte1_i, src_byte2_i};
    case (cfg_i.fmt) inside
      FMT_RGBA8888, FMT_RGB888: w0_1_d = {alpha, src_byte0_i};
      FMT_RGB565:               w0_1_d = t16;
      default:                  w0_1_d = {1'b0, t16[3:1], t16[15:4]}; // RGB4A3
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= v1_d;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      row1_q  <= texel_y_i[CoordW-1:2];
      col1_q  <= texel_x_i[CoordW-1:2];
      slot1_q <= slot1_d;
      wide1_q <= wide1_d;
      w0_1_q  <= w0_1_d;
      w1_1_q  <= w1_1_d;

      prod2_q <= ProdW'(row1_q) * ProdW'(cfg_i.tiles_x);
      col2_q  <= col1_q;
      slot2_q <= slot1_q;
      wide2_q <= wide1_q;
      w0_2_q  <= w0_1_q;
      w1_2_q  <= w1_1_q;

      item3_q <= item3_d;
    end
  end

  always_comb begin
    tile_idx = TileIdxW'(prod2_q) + TileIdxW'(col2_q);
    item3_d.offset    = wide2_q ? (OffsetW'({tile_idx, 6'b0}) | OffsetW'(slot2_q))
                                : (OffsetW'({tile_idx, 5'b0}) | OffsetW'(slot2_q));
    item3_d.word0     = w0_2_q;
    item3_d.word1     = w1_2_q;
    item3_d.two_words = wide2_q;
  end

  assign out_valid_o = v3_q;
  assign out_item_o  = item3_q;

endmodule

// ===== hw/rtl/tts_out.sv =====
// ----------------------------------------------------------------------------
// tts_out: output register and word sequencer
// Holds one placed texel and sends its one or two words in order.
// ----------------------------------------------------------------------------
module tts_out
  import tts_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  item_t               in_item_i,
  output logic                load_o,
  output logic                tvalid_o,
  input  logic                tready_i,
  output logic [OutDataW-1:0] tdata_o,
  output logic                tlast_o
);

  logic  valid_q, valid_d;
  logic  phase_q, phase_d;
  item_t item_q;
  logic  hs, last;
  logic [OffsetW-1:0] offset;
  logic [WordW-1:0]   word;

  assign last   = !item_q.two_words || phase_q;
  assign hs     = valid_q && tready_i;
  assign load_o = !valid_q || (hs && last);

  always_comb begin
    valid_d = valid_q;
    phase_d = phase_q;
    if (load_o) begin
      valid_d = in_valid_i;
      phase_d = 1'b0;
    end else if (hs) begin
      phase_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_o) begin
      item_q <= in_item_i;
    end
  end

  assign offset   = phase_q ? item_q.offset + HalfTileBytes : item_q.offset;
  assign word     = phase_q ? item_q.word1 : item_q.word0;
  assign tvalid_o = valid_q;
  assign tlast_o  = last;
  assign tdata_o  = OutDataW'({word, offset});

  a_phase_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> valid_q) else $error("second word pending without a texel");

  a_phase_needs_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> item_q.two_words) else $error("second word on a 16-bit format");

  a_first_then_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hs && !last) |=> (valid_q && phase_q))
    else $error("second word of a 32-bit texel lost");

endmodule

// ===== hw/rtl/texture_tile_swizzle_4x4.sv =====
// ----------------------------------------------------------------------------
// texture_tile_swizzle_4x4: places source texels into a 4x4 tiled texture
// Each input transaction is one texel; each output transaction is one 16-bit
// word with its byte offset in the tiled destination.
// ----------------------------------------------------------------------------
// A texel enters every cycle while the output keeps up. 16-bit formats
// (RGB565, RGBA4444) give one word per texel, so one texel per cycle; 32-bit
// formats (RGBA8888, RGB888) give an AR word then a GB word 32 bytes later,
// so the next texel waits for the second word on the single output port.
// Texels outside the whole tiles (or outside a small texture) are dropped
// and give no output. Textures narrower or shorter than 4 texels use one
// padded tile. The user must write the format and size registers only while
// no texel is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module texture_tile_swizzle_4x4
  import tts_pkg::*;
#(
  parameter int unsigned MaxDimension = MaxDimensionDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration writes: 0 format, 1 width, 2 height
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_addr_i,
  input  logic [DimW-1:0]     cfg_wdata_i,
  // texel input
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata: texel_x[9:0], texel_y[19:10], src_byte0[27:20], src_byte1[35:28],
  //        src_byte2[43:36], src_byte3[51:44], zero pad[55:52]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // word output
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata: dest_offset[21:0], dest_word[37:22], zero pad[39:38]
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic                m_axis_tlast    // last_word
);

  cfg_t  cfg;
  logic  load;
  logic  pipe_valid;
  item_t pipe_item;

  tts_cfg_regs #(
    .MaxDimension(MaxDimension)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  // whole pipeline advances when the output register can take a texel
  assign s_axis_tready = load;

  tts_pipe u_pipe (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (load),
    .in_valid_i (s_axis_tvalid),
    .texel_x_i  (s_axis_tdata[9:0]),
    .texel_y_i  (s_axis_tdata[19:10]),
    .src_byte0_i(s_axis_tdata[27:20]),
    .src_byte1_i(s_axis_tdata[35:28]),
    .src_byte2_i(s_axis_tdata[43:36]),
    .src_byte3_i(s_axis_tdata[51:44]),
    .cfg_i      (cfg),
    .out_valid_o(pipe_valid),
    .out_item_o (pipe_item)
  );

  tts_out u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(pipe_valid),
    .in_item_i (pipe_item),
    .load_o    (load),
    .tvalid_o  (m_axis_tvalid),
    .tready_i  (m_axis_tready),
    .tdata_o   (m_axis_tdata),
    .tlast_o   (m_axis_tlast)
  );

endmodule
